[rtl/signed_int_to_decimal_ascii_assert.svh]
// Assertion macros for the signed integer to decimal ASCII converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef SYNTHESIS
`define SITDA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SITDA_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SITDA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SITDA_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

[rtl/sitda_pkg.sv]
// Shared types and constants of the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps
package sitda_pkg;

	localparam int unsigned CHAR_W = 8;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;

	localparam int unsigned BCD_DIGIT_W = 4;
	localparam logic [BCD_DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
	localparam logic [BCD_DIGIT_W-1:0] DABBLE_ADJUST = 4'd3;
	localparam int unsigned DABBLE_BITS = 4;

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		B_IDLE,
		B_CONV,
		B_SCAN,
		B_EMIT
	} back_state_t;

endpackage

[rtl/sitda_front.sv]
// Front stage: takes a request, splits off the sign and forms the unsigned magnitude.
`timescale 1ns / 1ps
module sitda_front #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [VALUE_WIDTH-1:0] in_value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VALUE_WIDTH:0]   out_data
);

	logic                   valid_s1;
	logic [VALUE_WIDTH:0]   data_s1;
	logic                   neg;
	logic [VALUE_WIDTH-1:0] mag;

	assign neg = in_value[VALUE_WIDTH-1];
	assign mag = neg ? (~in_value + VALUE_WIDTH'(1)) : in_value;
	assign in_ready = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= {neg, mag};
		end
	end

endmodule

[rtl/sitda_queue.sv]
// Short request queue between the front and back stages.
`timescale 1ns / 1ps
module sitda_queue #(
	parameter int WIDTH = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int DEPTH = sitda_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[rtl/sitda_back.sv]
// Back stage: binary to BCD conversion by shift and add-three, then character output.
`timescale 1ns / 1ps
module sitda_back #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [VALUE_WIDTH:0]          req_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sitda_pkg::CHAR_W-1:0]  out_char,
	output logic                          out_last
);

	localparam int STEP_BITS = sitda_pkg::DABBLE_BITS;
	localparam int DIG_W = sitda_pkg::BCD_DIGIT_W;
	localparam int STEPS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int PAD_W = STEPS * STEP_BITS;
	localparam int DIGITS = ((VALUE_WIDTH - 1) * 1233) / 4096 + 2;
	localparam int BCD_W = DIGITS * DIG_W;
	localparam int CNT_W = $clog2(STEPS + 1);
	localparam int IDX_W = $clog2(DIGITS);

	sitda_pkg::back_state_t state_q, state_d;

	logic [PAD_W-1:0]              mag_q, mag_d;
	logic [BCD_W-1:0]              bcd_q, bcd_d;
	logic                          neg_q, neg_d;
	logic                          sign_pend_q, sign_pend_d;
	logic [CNT_W-1:0]              steps_q, steps_d;
	logic [IDX_W-1:0]              idx_q, idx_d;
	logic [IDX_W-1:0]              top_idx;
	logic [DIG_W-1:0]              digit;
	logic [BCD_W+PAD_W-1:0]        dabbled;
	logic                          out_valid_q, out_valid_d;
	logic [sitda_pkg::CHAR_W-1:0]  out_char_q, out_char_d;
	logic                          out_last_q, out_last_d;

	function automatic logic [BCD_W+PAD_W-1:0] dabble(input logic [BCD_W-1:0] b,
			input logic [PAD_W-1:0] m);
		logic [BCD_W-1:0] bb;
		logic [PAD_W-1:0] mm;
		bb = b;
		mm = m;
		for (int s = 0; s < STEP_BITS; s++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (bb[d*DIG_W +: DIG_W] >= sitda_pkg::DABBLE_LIMIT) begin
					bb[d*DIG_W +: DIG_W] = bb[d*DIG_W +: DIG_W] + sitda_pkg::DABBLE_ADJUST;
				end
			end
			bb = {bb[BCD_W-2:0], mm[PAD_W-1]};
			mm = {mm[PAD_W-2:0], 1'b0};
		end
		return {bb, mm};
	endfunction

	assign dabbled = dabble(bcd_q, mag_q);
	assign digit = bcd_q[idx_q*DIG_W +: DIG_W];

	always_comb begin
		top_idx = '0;
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_q[d*DIG_W +: DIG_W] != '0) begin
				top_idx = IDX_W'(d);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_char = out_char_q;
	assign out_last = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sitda_pkg::B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		mag_q <= mag_d;
		bcd_q <= bcd_d;
		neg_q <= neg_d;
		sign_pend_q <= sign_pend_d;
		steps_q <= steps_d;
		idx_q <= idx_d;
		out_char_q <= out_char_d;
		out_last_q <= out_last_d;
	end

	always_comb begin
		state_d = state_q;
		mag_d = mag_q;
		bcd_d = bcd_q;
		neg_d = neg_q;
		sign_pend_d = sign_pend_q;
		steps_d = steps_q;
		idx_d = idx_q;
		out_valid_d = out_valid_q && !out_ready;
		out_char_d = out_char_q;
		out_last_d = out_last_q;
		req_ready = 1'b0;
		case (state_q)
			sitda_pkg::B_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					neg_d = req_data[VALUE_WIDTH];
					mag_d = PAD_W'(req_data[VALUE_WIDTH-1:0]);
					bcd_d = '0;
					steps_d = CNT_W'(STEPS);
					state_d = sitda_pkg::B_CONV;
				end
			end
			sitda_pkg::B_CONV: begin
				bcd_d = dabbled[BCD_W+PAD_W-1:PAD_W];
				mag_d = dabbled[PAD_W-1:0];
				steps_d = steps_q - CNT_W'(1);
				if (steps_q == CNT_W'(1)) begin
					state_d = sitda_pkg::B_SCAN;
				end
			end
			sitda_pkg::B_SCAN: begin
				idx_d = top_idx;
				sign_pend_d = neg_q;
				state_d = sitda_pkg::B_EMIT;
			end
			sitda_pkg::B_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_valid_d = 1'b1;
					if (sign_pend_q) begin
						out_char_d = sitda_pkg::CHAR_MINUS;
						out_last_d = 1'b0;
						sign_pend_d = 1'b0;
					end else begin
						out_char_d = sitda_pkg::CHAR_ZERO
							+ sitda_pkg::CHAR_W'(digit);
						out_last_d = (idx_q == '0);
						if (idx_q == '0) begin
							state_d = sitda_pkg::B_IDLE;
						end else begin
							idx_d = idx_q - IDX_W'(1);
						end
					end
				end
			end
			default: begin
				state_d = sitda_pkg::B_IDLE;
			end
		endcase
	end

endmodule

[rtl/signed_int_to_decimal_ascii.sv]
// Each request on the slave side carries one two's complement integer of VALUE_WIDTH bits and
// yields its decimal text on the master side, one ASCII character per transfer, most
// significant first, with a leading minus sign for a negative value and tlast on the final
// digit. Zero gives the single character '0' and the most negative value converts exactly.
// The shift and add-three unit takes four magnitude bits per cycle, and the characters leave
// through a single output register. A two-entry queue lets the front accept further requests
// while a value is being converted or its text is stalled.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_assert.svh"
module signed_int_to_decimal_ascii #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// value (VALUE_WIDTH bits), zero padded to whole bytes
	input  logic [((VALUE_WIDTH + 7) / 8)*8-1:0] s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// character (8 bits)
	output logic [sitda_pkg::CHAR_W-1:0]        m_axis_tdata,
	output logic                                m_axis_tlast
);

	logic                 front_valid;
	logic                 front_ready;
	logic [VALUE_WIDTH:0] front_data;
	logic                 q_valid;
	logic                 q_ready;
	logic [VALUE_WIDTH:0] q_data;

	sitda_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_value  (s_axis_tdata[VALUE_WIDTH-1:0]),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_data  (front_data)
	);

	sitda_queue #(
		.WIDTH(VALUE_WIDTH + 1)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_data),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	sitda_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (q_valid),
		.req_ready (q_ready),
		.req_data  (q_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	// Only a minus sign or a decimal digit ever leaves the block.
	`SITDA_ASSERT(chk_char_set, clk, arst_n, m_axis_tvalid |-> (m_axis_tdata == sitda_pkg::CHAR_MINUS || (m_axis_tdata >= sitda_pkg::CHAR_ZERO && m_axis_tdata <= sitda_pkg::CHAR_ZERO + 8'd9)), "output character is neither a minus sign nor a digit")
	`SITDA_ASSERT_NEVER(chk_minus_not_last, clk, arst_n, m_axis_tvalid && m_axis_tlast && (m_axis_tdata == sitda_pkg::CHAR_MINUS), "minus sign marked as the last character")
	// A request handed to the queue is still waiting there a cycle on.
	`SITDA_ASSERT(chk_queue_holds, clk, arst_n, (front_valid && front_ready) |=> q_valid, "queue lost a request")

endmodule
